// ===== rtl/urd_pkg.sv =====
// shared constants, types and the segment decode for the ultrasonic range display
package urd_pkg;

    localparam int COUNT_BITS    = 16;
    localparam int SCALE_BITS    = 16;
    localparam int PROD_BITS     = COUNT_BITS + SCALE_BITS;
    localparam int RANGE_BITS    = 9;
    localparam int TIMER_BITS    = 8;
    localparam int ROUND_BITS    = 10;
    localparam int SEL_BITS      = 3;
    localparam int SEG_BITS      = 7;
    localparam int DIGIT_BITS    = 4;
    localparam int IDX_BITS      = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [RANGE_BITS-1:0] RANGE_MAX    = '1;
    localparam logic [SEG_BITS-1:0]   SEG_BLANK    = 7'h7F;
    localparam logic [TIMER_BITS-1:0] TRIG_RESET   = 8'd10;
    localparam logic [TIMER_BITS-1:0] DWELL_RESET  = 8'd100;
    localparam logic [ROUND_BITS-1:0] ROUNDS_RESET = 10'd1000;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET  = 16'd499;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TRIGGER_TICKS  = 2'd0,
        REG_DIGIT_DWELL    = 2'd1,
        REG_REFRESH_ROUNDS = 2'd2,
        REG_SCALE          = 2'd3
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_TRIG_LOW  = 5'b00001,
        PH_TRIG_HIGH = 5'b00010,
        PH_WAIT_ECHO = 5'b00100,
        PH_COUNT     = 5'b01000,
        PH_DISPLAY   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic                  trigger;
        logic [SEL_BITS-1:0]   digit_select;
        logic [SEG_BITS-1:0]   segments;
        logic [RANGE_BITS-1:0] distance;
        logic                  display_active;
    } t_result;

    // active-low a..g pattern for one decimal digit
    function automatic logic [SEG_BITS-1:0] seg_pattern(input logic [DIGIT_BITS-1:0] digit);
        logic [SEG_BITS-1:0] pat;
        case (digit)
            4'd0:    pat = 7'h40;
            4'd1:    pat = 7'h79;
            4'd2:    pat = 7'h24;
            4'd3:    pat = 7'h30;
            4'd4:    pat = 7'h19;
            4'd5:    pat = 7'h12;
            4'd6:    pat = 7'h02;
            4'd7:    pat = 7'h78;
            4'd8:    pat = 7'h00;
            4'd9:    pat = 7'h10;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

endpackage

// ===== rtl/urd_if.sv =====
// request channels of the ultrasonic range display: echo input, result output, register write
interface urd_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

interface urd_out_if;
    import urd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  trigger;
    logic [SEL_BITS-1:0]   digit_select;
    logic [SEG_BITS-1:0]   segments;
    logic [RANGE_BITS-1:0] distance;
    logic                  display_active;

    modport source (output valid, output trigger, output digit_select, output segments,
                    output distance, output display_active, input ready);
    modport sink   (input valid, input trigger, input digit_select, input segments,
                    input distance, input display_active, output ready);
endinterface

interface urd_cfg_if;
    import urd_pkg::*;
    logic                     valid;
    logic                     ready;
    t_cfg_idx                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ultrasonic_range_display.sv =====
// an accepted result goes into the output register, or the skid entry if that one is full
// throughput: one echo request per cycle; a two-entry output stage (register plus skid)
// keeps the input ready while one result waits, so ready drops only when both are full
// the distance multiply and digit split are combinational, each between state registers
// reset: synchronous, active low; phase returns to trigger low, registers to defaults,
// display blank with no digit selected, output stage empty
module ultrasonic_range_display (
    input  logic         i_clk,
    input  logic         i_rst_n,
    urd_in_if.sink       i_echo,
    urd_out_if.source    o_result,
    urd_cfg_if.sink      i_cfg
);
    import urd_pkg::*;

    // configuration
    logic [TIMER_BITS-1:0] r_trigger_ticks;
    logic [TIMER_BITS-1:0] r_digit_dwell;
    logic [ROUND_BITS-1:0] r_refresh_rounds;
    logic [SCALE_BITS-1:0] r_scale;

    // measurement and display state
    t_phase                r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [COUNT_BITS-1:0] r_pulse_count, n_pulse_count;
    logic [RANGE_BITS-1:0] r_range, n_range;
    logic [IDX_BITS-1:0]   r_digit_idx, n_digit_idx;
    logic [ROUND_BITS-1:0] r_round, n_round;
    logic [SEG_BITS-1:0]   r_shown_pattern, n_shown_pattern;
    logic [SEL_BITS-1:0]   r_shown_select, n_shown_select;

    // output stage
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic    w_in_fire;
    logic    w_out_fire;
    logic    w_cfg_fire;
    t_result w_result;

    assign i_echo.ready = !r_skid_valid;
    assign i_cfg.ready  = 1'b1;
    assign w_in_fire    = i_echo.valid && i_echo.ready;
    assign w_out_fire   = o_result.valid && o_result.ready;
    assign w_cfg_fire   = i_cfg.valid && i_cfg.ready;

    // timers, zero limits behave as one
    logic [TIMER_BITS-1:0] w_timer_inc;
    logic                  w_trig_done;
    logic                  w_dwell_done;
    logic [ROUND_BITS-1:0] w_round_inc;
    logic                  w_rounds_done;

    assign w_timer_inc   = r_timer + 1'b1;
    assign w_trig_done   = (w_timer_inc >= r_trigger_ticks) || (w_timer_inc == '0);
    assign w_dwell_done  = (w_timer_inc >= r_digit_dwell) || (w_timer_inc == '0);
    assign w_round_inc   = r_round + 1'b1;
    assign w_rounds_done = (w_round_inc >= r_refresh_rounds) || (w_round_inc == '0);

    // distance = (count * scale) >> 16, saturated to the display range
    logic [PROD_BITS-1:0]  w_product;
    logic [PROD_BITS-1:0]  w_dist_raw;
    logic [RANGE_BITS-1:0] w_dist_sat;

    assign w_product  = PROD_BITS'(r_pulse_count) * PROD_BITS'(r_scale);
    assign w_dist_raw = w_product >> SCALE_BITS;
    assign w_dist_sat = (w_dist_raw > PROD_BITS'(RANGE_MAX)) ? RANGE_MAX
                                                             : w_dist_raw[RANGE_BITS-1:0];

    // decimal split by reciprocal multiply, exact for values below 512
    logic [16:0]           w_mul10;
    logic [5:0]            w_quot10;
    logic [14:0]           w_mul100;
    logic [2:0]            w_hund;
    logic [DIGIT_BITS-1:0] w_units;
    logic [DIGIT_BITS-1:0] w_tens;
    logic [IDX_BITS-1:0]   w_idx;
    logic [DIGIT_BITS-1:0] w_digit;

    assign w_mul10  = 17'(r_range) * 17'd205;
    assign w_quot10 = w_mul10[16:11];
    assign w_mul100 = 15'(r_range) * 15'd41;
    assign w_hund   = w_mul100[14:12];
    assign w_units  = DIGIT_BITS'(r_range - (9'(w_quot10) * 9'd10));
    assign w_tens   = DIGIT_BITS'(w_quot10 - (6'(w_hund) * 6'd10));
    assign w_idx    = (r_digit_idx > 2'd2) ? 2'd0 : r_digit_idx;

    always_comb begin
        case (w_idx)
            2'd0:    w_digit = w_units;
            2'd1:    w_digit = w_tens;
            default: w_digit = DIGIT_BITS'(w_hund);
        endcase
    end

    // phase sequencer, one step per accepted tick
    always_comb begin
        n_phase         = r_phase;
        n_timer         = r_timer;
        n_pulse_count   = r_pulse_count;
        n_range         = r_range;
        n_digit_idx     = r_digit_idx;
        n_round         = r_round;
        n_shown_pattern = r_shown_pattern;
        n_shown_select  = r_shown_select;
        case (r_phase)
            PH_TRIG_LOW: begin
                n_timer = w_trig_done ? '0 : w_timer_inc;
                if (w_trig_done) begin
                    n_phase = PH_TRIG_HIGH;
                end
            end
            PH_TRIG_HIGH: begin
                n_timer = w_trig_done ? '0 : w_timer_inc;
                if (w_trig_done) begin
                    n_phase = PH_WAIT_ECHO;
                end
            end
            PH_WAIT_ECHO: begin
                if (i_echo.echo_level) begin
                    n_pulse_count = COUNT_BITS'(1);
                    n_phase       = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo.echo_level) begin
                    if (r_pulse_count != '1) begin
                        n_pulse_count = r_pulse_count + 1'b1;
                    end
                end else begin
                    n_range     = w_dist_sat;
                    n_phase     = PH_DISPLAY;
                    n_timer     = '0;
                    n_digit_idx = '0;
                    n_round     = '0;
                end
            end
            PH_DISPLAY: begin
                n_shown_select  = SEL_BITS'(1) << w_idx;
                n_shown_pattern = seg_pattern(w_digit);
                n_digit_idx     = w_idx;
                n_timer         = w_dwell_done ? '0 : w_timer_inc;
                if (w_dwell_done) begin
                    if (w_idx == 2'd2) begin
                        n_digit_idx = '0;
                        n_round     = w_rounds_done ? '0 : w_round_inc;
                        if (w_rounds_done) begin
                            n_phase = PH_TRIG_LOW;
                        end
                    end else begin
                        n_digit_idx = w_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_TRIG_LOW;
                n_timer = '0;
            end
        endcase
    end

    // trigger and display_active reflect the phase at the start of the tick
    always_comb begin
        w_result.trigger        = (r_phase == PH_TRIG_HIGH);
        w_result.digit_select   = n_shown_select;
        w_result.segments       = n_shown_pattern;
        w_result.distance       = n_range;
        w_result.display_active = (r_phase == PH_DISPLAY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks  <= TRIG_RESET;
            r_digit_dwell    <= DWELL_RESET;
            r_refresh_rounds <= ROUNDS_RESET;
            r_scale          <= SCALE_RESET;
        end else if (w_cfg_fire) begin
            case (i_cfg.index)
                REG_TRIGGER_TICKS:  r_trigger_ticks  <= i_cfg.data[TIMER_BITS-1:0];
                REG_DIGIT_DWELL:    r_digit_dwell    <= i_cfg.data[TIMER_BITS-1:0];
                REG_REFRESH_ROUNDS: r_refresh_rounds <= i_cfg.data[ROUND_BITS-1:0];
                REG_SCALE:          r_scale          <= i_cfg.data[SCALE_BITS-1:0];
                default:            r_scale          <= r_scale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_TRIG_LOW;
            r_timer         <= '0;
            r_pulse_count   <= '0;
            r_range         <= '0;
            r_digit_idx     <= '0;
            r_round         <= '0;
            r_shown_pattern <= SEG_BLANK;
            r_shown_select  <= '0;
        end else if (w_in_fire) begin
            r_phase         <= n_phase;
            r_timer         <= n_timer;
            r_pulse_count   <= n_pulse_count;
            r_range         <= n_range;
            r_digit_idx     <= n_digit_idx;
            r_round         <= n_round;
            r_shown_pattern <= n_shown_pattern;
            r_shown_select  <= n_shown_select;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire) begin
            r_out <= r_skid_valid ? r_skid : w_result;
        end else if (w_in_fire) begin
            if (r_out_valid) begin
                r_skid <= w_result;
            end else begin
                r_out <= w_result;
            end
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.trigger        = r_out.trigger;
    assign o_result.digit_select   = r_out.digit_select;
    assign o_result.segments       = r_out.segments;
    assign o_result.distance       = r_out.distance;
    assign o_result.display_active = r_out.display_active;

endmodule

// ===== rtl/urd_checker.sv =====
// port-level checks for the ultrasonic range display, bound to the top level
module urd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_trigger,
    input logic [urd_pkg::SEL_BITS-1:0]   i_digit_select,
    input logic [urd_pkg::SEG_BITS-1:0]   i_segments,
    input logic [urd_pkg::RANGE_BITS-1:0] i_distance,
    input logic                           i_display_active
);
    import urd_pkg::*;

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_trigger)
            && $stable(i_digit_select) && $stable(i_segments)
            && $stable(i_distance) && $stable(i_display_active))
        else $error("result changed while stalled");

    // after every accepted request the output is valid in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted request left no result");

    // input backpressure only when the output stage already holds results
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with an empty output stage");

    a_select_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> $onehot0(i_digit_select))
        else $error("more than one digit selected");

    // trigger pulse and display refresh are separate phases
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_trigger && i_display_active))
        else $error("trigger high during display refresh");

endmodule

bind ultrasonic_range_display urd_checker u_urd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_echo.valid),
    .i_in_ready       (i_echo.ready),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_trigger        (o_result.trigger),
    .i_digit_select   (o_result.digit_select),
    .i_segments       (o_result.segments),
    .i_distance       (o_result.distance),
    .i_display_active (o_result.display_active)
);
